// ----- src/ssd_pkg.sv -----
// shared types and constants for the stereo silence detector
`default_nettype none

package ssd_pkg;

   // register field widths
   localparam int RATE_BITS   = 17;
   localparam int TOL_BITS    = 8;
   localparam int SECS_BITS   = 8;
   localparam int COUNT_BITS  = 32;
   localparam int CSR_IDX_BITS = 2;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_SAMPLES_PER_SECOND     = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SILENCE_TOLERANCE      = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SKIP_START_SECONDS     = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DETECT_SILENCE_SECONDS = 2'd3;

   // register reset values
   localparam logic [RATE_BITS-1:0] RATE_RESET = 17'd44100;
   localparam logic [TOL_BITS-1:0]  TOL_RESET  = 8'd7;
   localparam logic [SECS_BITS-1:0] SKIP_RESET = 8'd0;
   localparam logic [SECS_BITS-1:0] DETECT_RESET = 8'd0;

   // action codes
   localparam logic ACTION_SAMPLE  = 1'b0;
   localparam logic ACTION_RESTART = 1'b1;

   // configuration as seen by the detector
   typedef struct packed {
      logic [RATE_BITS-1:0] samples_per_second;
      logic [TOL_BITS-1:0]  silence_tolerance;
      logic [SECS_BITS-1:0] skip_start_seconds;
      logic [SECS_BITS-1:0] detect_silence_seconds;
   } cfg_type;

   // per-sample verdict from the detector
   typedef struct packed {
      logic                  keep;
      logic [COUNT_BITS-1:0] silent_seconds;
      logic                  limit_reached;
   } verdict_type;

endpackage

`default_nettype wire

// ----- src/stereo_silence_detect_skip.sv -----
// top level of the stereo silence detector with leading-silence skip
`default_nettype none

// Stereo silence detector. Each transfer on req_ is either a stereo sample or
// a restart (req_action high). A sample is silent when both channels moved by
// at most the tolerance since the previous sample; runs of silent samples are
// counted into whole seconds, and any sound clears the count. After a restart
// with a non-zero skip target, samples come out with rsp_keep low until the
// first sound or until the silence seconds reach the target. Every sample
// yields one rsp_ transfer; a restart yields none. An item is held in the
// input register, then the detector decision and state update move it into
// the result register, so one item per clock is taken while rsp_stall does
// not hold the result register. Configuration writes on csr_ take effect on
// the next cycle and belong to idle periods only.

module stereo_silence_detect_skip #(
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // sample channel
   input  wire logic                              req_valid,
   output      logic                              req_stall,
   input  wire logic                              req_action,
   input  wire logic signed [SAMPLE_BITS-1:0]     req_left_sample,
   input  wire logic signed [SAMPLE_BITS-1:0]     req_right_sample,
   // result channel
   output      logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   output      logic signed [SAMPLE_BITS-1:0]     rsp_out_left,
   output      logic signed [SAMPLE_BITS-1:0]     rsp_out_right,
   output      logic                              rsp_keep,
   output      logic [ssd_pkg::COUNT_BITS-1:0]    rsp_silent_seconds,
   output      logic                              rsp_limit_reached,
   // configuration
   input  wire logic                              csr_write_enable,
   input  wire logic [ssd_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [ssd_pkg::RATE_BITS-1:0]     csr_write_data
);

   ssd_pkg::cfg_type     cfg;
   ssd_pkg::verdict_type verdict;

   logic                          in_valid_ff;
   logic                          in_action_ff;
   logic signed [SAMPLE_BITS-1:0] in_left_ff, in_right_ff;

   logic                          out_valid_ff;
   logic signed [SAMPLE_BITS-1:0] out_left_ff, out_right_ff;
   ssd_pkg::verdict_type          out_verdict_ff;

   logic advance, req_take;

   ssd_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   ssd_core #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .fire         (advance),
      .action       (in_action_ff),
      .left_sample  (in_left_ff),
      .right_sample (in_right_ff),
      .verdict      (verdict)
   );

   // the held item moves on when the result register is free or being emptied
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_action_ff <= req_action;
         in_left_ff   <= req_left_sample;
         in_right_ff  <= req_right_sample;
      end
   end

   // result register, loaded only for samples
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= (in_action_ff == ssd_pkg::ACTION_SAMPLE);
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && (in_action_ff == ssd_pkg::ACTION_SAMPLE)) begin
         out_left_ff    <= in_left_ff;
         out_right_ff   <= in_right_ff;
         out_verdict_ff <= verdict;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_out_left       = out_left_ff;
   assign rsp_out_right      = out_right_ff;
   assign rsp_keep           = out_verdict_ff.keep;
   assign rsp_silent_seconds = out_verdict_ff.silent_seconds;
   assign rsp_limit_reached  = out_verdict_ff.limit_reached;

endmodule

`default_nettype wire

// ----- src/ssd_csr.sv -----
// configuration registers of the silence detector
`default_nettype none

module ssd_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_enable,
   input  wire logic [ssd_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [ssd_pkg::RATE_BITS-1:0]      csr_write_data,
   output      ssd_pkg::cfg_type                   cfg
);

   ssd_pkg::cfg_type cfg_ff;
   ssd_pkg::cfg_type cfg_in;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            ssd_pkg::CSR_SAMPLES_PER_SECOND: begin
               cfg_in.samples_per_second = csr_write_data;
            end
            ssd_pkg::CSR_SILENCE_TOLERANCE: begin
               cfg_in.silence_tolerance = csr_write_data[ssd_pkg::TOL_BITS-1:0];
            end
            ssd_pkg::CSR_SKIP_START_SECONDS: begin
               cfg_in.skip_start_seconds = csr_write_data[ssd_pkg::SECS_BITS-1:0];
            end
            ssd_pkg::CSR_DETECT_SILENCE_SECONDS: begin
               cfg_in.detect_silence_seconds = csr_write_data[ssd_pkg::SECS_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.samples_per_second     <= ssd_pkg::RATE_RESET;
         cfg_ff.silence_tolerance      <= ssd_pkg::TOL_RESET;
         cfg_ff.skip_start_seconds     <= ssd_pkg::SKIP_RESET;
         cfg_ff.detect_silence_seconds <= ssd_pkg::DETECT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- src/ssd_core.sv -----
// silence tracking state and per-sample decision logic
`default_nettype none

module ssd_core #(
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ssd_pkg::cfg_type              cfg,
   input  wire logic                          fire,
   input  wire logic                          action,
   input  wire logic signed [SAMPLE_BITS-1:0] left_sample,
   input  wire logic signed [SAMPLE_BITS-1:0] right_sample,
   output      ssd_pkg::verdict_type          verdict
);

   localparam int DIFF_BITS = SAMPLE_BITS + 1;
   localparam int RATE_BITS = ssd_pkg::RATE_BITS;
   localparam int CNT_BITS  = ssd_pkg::COUNT_BITS;

   logic signed [SAMPLE_BITS-1:0]    last_left_ff,  last_left_in;
   logic signed [SAMPLE_BITS-1:0]    last_right_ff, last_right_in;
   logic [RATE_BITS-1:0]             sample_count_ff, sample_count_in;
   logic [CNT_BITS-1:0]              second_count_ff, second_count_in;
   logic [ssd_pkg::SECS_BITS-1:0]    skip_target_ff, skip_target_in;

   logic signed [DIFF_BITS-1:0] diff_left, diff_right;
   logic [DIFF_BITS-1:0]        mag_left, mag_right, tol_wide;
   logic                        quiet, active, was_armed;
   logic [RATE_BITS:0]          count_inc;
   logic [RATE_BITS:0]          count_wrap;
   logic [CNT_BITS-1:0]         secs_inc;

   // per-channel change against the previous sample
   always_comb begin
      diff_left  = DIFF_BITS'(left_sample)  - DIFF_BITS'(last_left_ff);
      diff_right = DIFF_BITS'(right_sample) - DIFF_BITS'(last_right_ff);
      mag_left   = diff_left[DIFF_BITS-1]  ? DIFF_BITS'(-diff_left)  : DIFF_BITS'(diff_left);
      mag_right  = diff_right[DIFF_BITS-1] ? DIFF_BITS'(-diff_right) : DIFF_BITS'(diff_right);
      tol_wide   = DIFF_BITS'(cfg.silence_tolerance);
      quiet      = (mag_left <= tol_wide) && (mag_right <= tol_wide);
   end

   // counter arithmetic
   always_comb begin
      count_inc  = {1'b0, sample_count_ff} + (RATE_BITS+1)'(1);
      count_wrap = count_inc - {1'b0, cfg.samples_per_second};
      secs_inc   = (second_count_ff == '1) ? second_count_ff
                                           : second_count_ff + CNT_BITS'(1);
   end

   // next state and verdict
   always_comb begin
      last_left_in    = last_left_ff;
      last_right_in   = last_right_ff;
      sample_count_in = sample_count_ff;
      second_count_in = second_count_ff;
      skip_target_in  = skip_target_ff;
      active    = (cfg.detect_silence_seconds != '0) || (skip_target_ff != '0);
      was_armed = (skip_target_ff != '0);

      if (action == ssd_pkg::ACTION_RESTART) begin
         last_left_in    = '0;
         last_right_in   = '0;
         sample_count_in = '0;
         second_count_in = '0;
         skip_target_in  = cfg.skip_start_seconds;
      end else if (active) begin
         last_left_in  = left_sample;
         last_right_in = right_sample;
         if (quiet) begin
            if (count_inc >= {1'b0, cfg.samples_per_second}) begin
               sample_count_in = count_wrap[RATE_BITS-1:0];
               second_count_in = secs_inc;
               if (was_armed && (secs_inc >= CNT_BITS'(skip_target_ff))) begin
                  skip_target_in  = '0;
                  second_count_in = '0;
               end
            end else begin
               sample_count_in = count_inc[RATE_BITS-1:0];
            end
         end else begin
            sample_count_in = '0;
            second_count_in = '0;
            skip_target_in  = '0;
         end
      end

      verdict.keep           = !(was_armed && (skip_target_in != '0));
      verdict.silent_seconds = second_count_in;
      verdict.limit_reached  = (cfg.detect_silence_seconds != '0) &&
                               (second_count_in >= CNT_BITS'(cfg.detect_silence_seconds));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_left_ff    <= '0;
         last_right_ff   <= '0;
         sample_count_ff <= '0;
         second_count_ff <= '0;
         skip_target_ff  <= '0;
      end else if (fire) begin
         last_left_ff    <= last_left_in;
         last_right_ff   <= last_right_in;
         sample_count_ff <= sample_count_in;
         second_count_ff <= second_count_in;
         skip_target_ff  <= skip_target_in;
      end
   end

endmodule

`default_nettype wire

// ----- tb/sv/stereo_silence_detect_skip_tb.sv -----
// self-checking testbench for the stereo silence detector with leading-silence skip
`default_nettype none

module stereo_silence_detect_skip_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SMP_BITS     = 16;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 160;
   localparam logic [ssd_pkg::RATE_BITS-1:0] RATE_MAX = '1;

   typedef logic signed [SMP_BITS-1:0] pcm_type;

   // one expected result transfer
   typedef struct packed {
      pcm_type              left;
      pcm_type              right;
      ssd_pkg::verdict_type verdict;
   } sample_result_type;

   // shadow of the detector and the results it owes
   class silence_scoreboard;
      logic [ssd_pkg::RATE_BITS-1:0]  rate;
      logic [ssd_pkg::TOL_BITS-1:0]   tol;
      logic [ssd_pkg::SECS_BITS-1:0]  skip_cfg;
      logic [ssd_pkg::SECS_BITS-1:0]  detect_cfg;
      pcm_type                        prev_left;
      pcm_type                        prev_right;
      logic [ssd_pkg::RATE_BITS-1:0]  run_samples;
      logic [ssd_pkg::COUNT_BITS-1:0] run_seconds;
      logic [ssd_pkg::SECS_BITS-1:0]  skip_target;
      sample_result_type              owed[$];
      int                             errors;

      function new();
         rate        = ssd_pkg::RATE_RESET;
         tol         = ssd_pkg::TOL_RESET;
         skip_cfg    = ssd_pkg::SKIP_RESET;
         detect_cfg  = ssd_pkg::DETECT_RESET;
         skip_target = '0;
         errors      = 0;
         clear_track();
      endfunction

      function void clear_track();
         prev_left   = '0;
         prev_right  = '0;
         run_samples = '0;
         run_seconds = '0;
      endfunction

      function void write_reg(logic [ssd_pkg::CSR_IDX_BITS-1:0] idx,
                              logic [ssd_pkg::RATE_BITS-1:0] val);
         case (idx)
            ssd_pkg::CSR_SAMPLES_PER_SECOND:     rate       = val;
            ssd_pkg::CSR_SILENCE_TOLERANCE:      tol        = val[ssd_pkg::TOL_BITS-1:0];
            ssd_pkg::CSR_SKIP_START_SECONDS:     skip_cfg   = val[ssd_pkg::SECS_BITS-1:0];
            ssd_pkg::CSR_DETECT_SILENCE_SECONDS: detect_cfg = val[ssd_pkg::SECS_BITS-1:0];
            default: ;
         endcase
      endfunction

      function bit close_enough(pcm_type now, pcm_type prev);
         int diff;
         diff = int'(now) - int'(prev);
         if (diff < 0) diff = -diff;
         return diff <= int'(tol);
      endfunction

      // accepted request: advance the shadow state and queue the result it causes
      function void note_input(logic act, pcm_type l, pcm_type r);
         sample_result_type           res;
         logic                        armed_before;
         logic [ssd_pkg::RATE_BITS:0] next_count;
         logic                        keep;
         if (act == ssd_pkg::ACTION_RESTART) begin
            clear_track();
            skip_target = skip_cfg;
            return;
         end
         keep = 1'b1;
         if (detect_cfg != 0 || skip_target != 0) begin
            armed_before = (skip_target != 0);
            if (close_enough(l, prev_left) && close_enough(r, prev_right)) begin
               next_count = {1'b0, run_samples} + 1'b1;
               if (next_count >= {1'b0, rate}) begin
                  next_count = next_count - {1'b0, rate};
                  if (run_seconds != '1) run_seconds = run_seconds + 1'b1;
                  // skip target reached: release and restart the seconds count
                  if (skip_target != 0 && run_seconds >= skip_target) begin
                     skip_target = '0;
                     run_seconds = '0;
                  end
               end
               run_samples = next_count[ssd_pkg::RATE_BITS-1:0];
            end else begin
               run_samples = '0;
               run_seconds = '0;
               skip_target = '0;
            end
            prev_left  = l;
            prev_right = r;
            if (armed_before && skip_target != 0) keep = 1'b0;
         end
         res.left                  = l;
         res.right                 = r;
         res.verdict.keep          = keep;
         res.verdict.silent_seconds = run_seconds;
         res.verdict.limit_reached = (detect_cfg != 0 && run_seconds >= detect_cfg);
         owed.push_back(res);
      endfunction

      function void compare_field(string label, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, label, want, got);
            errors++;
         end
      endfunction

      function void check_result(pcm_type l, pcm_type r, logic keep,
                                 logic [ssd_pkg::COUNT_BITS-1:0] secs, logic limit);
         sample_result_type want;
         if (owed.size() == 0) begin
            $display("%0t: unexpected result, expected none actual left %h right %h",
                     $time, l, r);
            errors++;
            return;
         end
         want = owed.pop_front();
         compare_field("out_left", 32'(want.left), 32'(l));
         compare_field("out_right", 32'(want.right), 32'(r));
         compare_field("keep", 32'(want.verdict.keep), 32'(keep));
         compare_field("silent_seconds", want.verdict.silent_seconds, secs);
         compare_field("limit_reached", 32'(want.verdict.limit_reached), 32'(limit));
      endfunction

      function int pending();
         return owed.size();
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic                             req_action = ssd_pkg::ACTION_SAMPLE;
   pcm_type                          req_left_sample = '0;
   pcm_type                          req_right_sample = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   pcm_type                          rsp_out_left;
   pcm_type                          rsp_out_right;
   logic                             rsp_keep;
   logic [ssd_pkg::COUNT_BITS-1:0]   rsp_silent_seconds;
   logic                             rsp_limit_reached;
   logic                             csr_write_enable = 1'b0;
   logic [ssd_pkg::CSR_IDX_BITS-1:0] csr_index = ssd_pkg::CSR_SAMPLES_PER_SECOND;
   logic [ssd_pkg::RATE_BITS-1:0]    csr_write_data = '0;

   silence_scoreboard sb = new();
   bit                gaps_on = 1'b1;
   int                stall_run = 0;

   stereo_silence_detect_skip #(
      .SAMPLE_BITS(SMP_BITS)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_left_sample   (req_left_sample),
      .req_right_sample  (req_right_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_left      (rsp_out_left),
      .rsp_out_right     (rsp_out_right),
      .rsp_keep          (rsp_keep),
      .rsp_silent_seconds(rsp_silent_seconds),
      .rsp_limit_reached (rsp_limit_reached),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   // clock generation
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // result side back-pressure in short random bursts
   always @(posedge clock) begin
      if (stall_run > 0) stall_run = stall_run - 1;
      else if (gaps_on && $urandom_range(0, 5) == 0) stall_run = $urandom_range(1, 4);
      rsp_stall <= (stall_run > 0);
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_out_left, rsp_out_right, rsp_keep, rsp_silent_seconds,
                         rsp_limit_reached);
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   // present one request and hold it until the transfer completes
   task automatic send_item(input logic act, input pcm_type l, input pcm_type r);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= act;
      req_left_sample  <= l;
      req_right_sample <= r;
      do @(posedge clock); while (req_stall);
      sb.note_input(act, l, r);
   endtask

   task automatic wait_idle();
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [ssd_pkg::CSR_IDX_BITS-1:0] idx,
                            input logic [ssd_pkg::RATE_BITS-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   // write all four registers once the detector has gone quiet
   task automatic configure(input int rate, input int tol, input int skip, input int detect);
      logic [ssd_pkg::RATE_BITS-ssd_pkg::TOL_BITS-1:0] junk;
      req_valid <= 1'b0;
      wait_idle();
      write_csr(ssd_pkg::CSR_SAMPLES_PER_SECOND, rate[ssd_pkg::RATE_BITS-1:0]);
      // upper data bits of the narrow registers carry noise
      junk = (ssd_pkg::RATE_BITS-ssd_pkg::TOL_BITS)'($urandom);
      write_csr(ssd_pkg::CSR_SILENCE_TOLERANCE, {junk, tol[ssd_pkg::TOL_BITS-1:0]});
      junk = (ssd_pkg::RATE_BITS-ssd_pkg::TOL_BITS)'($urandom);
      write_csr(ssd_pkg::CSR_SKIP_START_SECONDS, {junk, skip[ssd_pkg::SECS_BITS-1:0]});
      junk = (ssd_pkg::RATE_BITS-ssd_pkg::TOL_BITS)'($urandom);
      write_csr(ssd_pkg::CSR_DETECT_SILENCE_SECONDS,
                {junk, detect[ssd_pkg::SECS_BITS-1:0]});
      csr_write_enable <= 1'b0;
   endtask

   // a sample within span of the previous one, reflected to stay in range
   function automatic pcm_type nudge(pcm_type base, int span);
      int d;
      int v;
      d = int'($urandom_range(0, 2 * span)) - span;
      v = int'(base) + d;
      if (v > 32767 || v < -32768) v = int'(base) - d;
      return pcm_type'(v);
   endfunction

   // a sample just past the tolerance from the previous one
   function automatic pcm_type step_out(pcm_type base, int tol);
      int d;
      int v;
      d = tol + 1 + int'($urandom_range(0, 2));
      if ($urandom_range(0, 1)) d = -d;
      v = int'(base) + d;
      if (v > 32767 || v < -32768) v = int'(base) - d;
      return pcm_type'(v);
   endfunction

   function automatic pcm_type any_sample();
      case ($urandom_range(0, 11))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return 16'sh0000;
         3:       return 16'shFFFF;
         default: return pcm_type'($urandom);
      endcase
   endfunction

   // main stimulus
   initial begin
      int      phase;
      int      n;
      int      pick;
      int      quiet_pct;
      int      tol_now;
      pcm_type l;
      pcm_type r;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: detector idle, nothing tracked
      send_item(ssd_pkg::ACTION_SAMPLE, 16'sd0, 16'sd0);
      send_item(ssd_pkg::ACTION_SAMPLE, 16'sh7FFF, 16'sh8000);
      send_item(ssd_pkg::ACTION_RESTART, 16'sd5, -16'sd5);
      send_item(ssd_pkg::ACTION_SAMPLE, -16'sd1, 16'sd1);

      // skip released by seconds, then by sound, tolerance boundary
      configure(2, 3, 2, 1);
      send_item(ssd_pkg::ACTION_RESTART, 16'sd0, 16'sd0);
      send_item(ssd_pkg::ACTION_SAMPLE, 16'sd0, 16'sd0);
      send_item(ssd_pkg::ACTION_SAMPLE, 16'sd3, -16'sd3);
      send_item(ssd_pkg::ACTION_SAMPLE, 16'sd3, -16'sd3);
      send_item(ssd_pkg::ACTION_SAMPLE, 16'sd3, -16'sd3);
      send_item(ssd_pkg::ACTION_SAMPLE, 16'sd7, -16'sd3);
      send_item(ssd_pkg::ACTION_RESTART, -16'sd1, 16'sd1);
      send_item(ssd_pkg::ACTION_SAMPLE, 16'sd0, 16'sd4);
      send_item(ssd_pkg::ACTION_SAMPLE, 16'sh7FFF, 16'sh8000);
      send_item(ssd_pkg::ACTION_SAMPLE, 16'sh8000, 16'sh7FFF);
      send_item(ssd_pkg::ACTION_SAMPLE, 16'sh8000, 16'sh7FFF);

      // zero rate, widest tolerance, largest targets
      configure(0, 255, 255, 255);
      send_item(ssd_pkg::ACTION_RESTART, 16'sd0, 16'sd0);
      send_item(ssd_pkg::ACTION_SAMPLE, 16'sd255, -16'sd255);
      send_item(ssd_pkg::ACTION_SAMPLE, 16'sd0, -16'sd255);
      send_item(ssd_pkg::ACTION_SAMPLE, 16'sd256, -16'sd255);
      send_item(ssd_pkg::ACTION_SAMPLE, 16'sd0, 16'sd0);
      send_item(ssd_pkg::ACTION_SAMPLE, 16'sd0, 16'sd256);

      // random phases, mostly silent runs broken by sound and restarts
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: configure(1, 255, 255, 255);
            1: configure(RATE_MAX, 0, 1, 1);
            2: configure(0, 5, 0, 2);
            3: configure(3, 0, 0, 0);
            default: begin
               configure(($urandom_range(0, 5) == 0) ? $urandom_range(1, RATE_MAX)
                                                     : $urandom_range(1, 6),
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 12),
                         ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 4),
                         ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 4));
            end
         endcase
         gaps_on   = (phase != PHASES - 1) && ($urandom_range(0, 4) != 0);
         quiet_pct = $urandom_range(55, 95);
         tol_now   = int'(sb.tol);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
               send_item(ssd_pkg::ACTION_RESTART, any_sample(), any_sample());
            end else if (pick < quiet_pct) begin
               l = nudge(sb.prev_left, tol_now);
               r = nudge(sb.prev_right, tol_now);
               send_item(ssd_pkg::ACTION_SAMPLE, l, r);
            end else if (pick < quiet_pct + (100 - quiet_pct) / 2) begin
               // one channel just loud enough, the other quiet
               if ($urandom_range(0, 1)) begin
                  l = step_out(sb.prev_left, tol_now);
                  r = nudge(sb.prev_right, tol_now);
               end else begin
                  l = nudge(sb.prev_left, tol_now);
                  r = step_out(sb.prev_right, tol_now);
               end
               send_item(ssd_pkg::ACTION_SAMPLE, l, r);
            end else begin
               send_item(ssd_pkg::ACTION_SAMPLE, any_sample(), any_sample());
            end
         end
      end

      // drain and report
      req_valid <= 1'b0;
      wait_idle();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
src/ssd_pkg.sv
src/ssd_csr.sv
src/ssd_core.sv
src/stereo_silence_detect_skip.sv
tb/sv/stereo_silence_detect_skip_tb.sv
